[src/lbm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbm_pkg
// shared types and constants for the 8-bit layer blend pipeline
// ----------------------------------------------------------------------------
package lbm_pkg;

	localparam int unsigned NUM_CH   = 3;
	localparam int unsigned DIV_BITS = 8;

	localparam logic [4:0] MODE_NORMAL     = 5'd0;
	localparam logic [4:0] MODE_MULTIPLY   = 5'd1;
	localparam logic [4:0] MODE_ADD        = 5'd2;
	localparam logic [4:0] MODE_SUBTRACT   = 5'd3;
	localparam logic [4:0] MODE_SCREEN     = 5'd4;
	localparam logic [4:0] MODE_OVERLAY    = 5'd5;
	localparam logic [4:0] MODE_HARD_LIGHT = 5'd6;
	localparam logic [4:0] MODE_SOFT_LIGHT = 5'd7;
	localparam logic [4:0] MODE_DODGE      = 5'd8;
	localparam logic [4:0] MODE_BURN       = 5'd9;
	localparam logic [4:0] MODE_LIN_BURN   = 5'd10;
	localparam logic [4:0] MODE_VIVID      = 5'd11;
	localparam logic [4:0] MODE_LIN_LIGHT  = 5'd12;
	localparam logic [4:0] MODE_PIN_LIGHT  = 5'd13;
	localparam logic [4:0] MODE_DARKEN     = 5'd14;
	localparam logic [4:0] MODE_LIGHTEN    = 5'd15;
	localparam logic [4:0] MODE_DIFFERENCE = 5'd16;
	localparam logic [4:0] MODE_LUM_ADD    = 5'd17;
	localparam logic [4:0] MODE_LUM_DODGE  = 5'd18;

	typedef logic [4:0] mode_t;

	// how the final stage forms a channel
	typedef enum logic [1:0] {
		KIND_SIMPLE = 2'd0,
		KIND_DIV    = 2'd1,
		KIND_BURN   = 2'd2,
		KIND_SOFT   = 2'd3
	} kind_t;

	// values that ride alongside the divider
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  simple;
		logic [15:0] soft_m;
		logic [7:0]  soft_n;
		logic        apply;
	} side_t;

	typedef struct packed {
		logic [15:0] num;
		logic [7:0]  den;
	} div_req_t;

	// exact x / 255 for x <= 65025
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage

[src/lbm_pix_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbm_pix_in_if
// source/destination pixel request channel
// ----------------------------------------------------------------------------
interface lbm_pix_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] src_red;
	logic [7:0] src_green;
	logic [7:0] src_blue;
	logic [7:0] dst_red;
	logic [7:0] dst_green;
	logic [7:0] dst_blue;
	logic [7:0] alpha;

	modport source (output valid, src_red, src_green, src_blue,
		dst_red, dst_green, dst_blue, alpha, input ready);
	modport sink (input valid, src_red, src_green, src_blue,
		dst_red, dst_green, dst_blue, alpha, output ready);
endinterface

[src/lbm_pix_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbm_pix_out_if
// blended pixel request channel
// ----------------------------------------------------------------------------
interface lbm_pix_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       apply_alpha;

	modport source (output valid, out_red, out_green, out_blue, apply_alpha,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, apply_alpha,
		output ready);
endinterface

[src/layer_blend_mode_8bit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_blend_mode_8bit
// per-pixel 8-bit rgb layer blend, 19 modes, saturated channels
// ----------------------------------------------------------------------------
// channel    dir  handshake     payload
// pix_in     in   valid/ready   src rgb, dst rgb, alpha
// pix_out    out  valid/ready   out rgb, apply_alpha
// cfg        in   cfg_we        cfg_data = blend_mode
//
// one pixel per cycle while the output is not stalled; 14 register stages
// (4 front stages, 9 divider stages, 1 output register)
// the whole pipe moves together and holds when the output is full and stalled
// arst_n clears valid bits and blend_mode; data registers are not reset
// ----------------------------------------------------------------------------
module layer_blend_mode_8bit (
	input  logic          clk,
	input  logic          arst_n,
	lbm_pix_in_if.sink    pix_in,
	lbm_pix_out_if.source pix_out,
	input  logic          cfg_we,
	input  logic [4:0]    cfg_data
);
	import lbm_pkg::*;

	// front stages plus divider load and bit stages
	localparam int unsigned PIPE_LEN = 4 + DIV_BITS + 1;

	mode_t                mode_q;
	logic [PIPE_LEN-1:0]  vld_q;
	logic                 out_vld_q;
	logic                 en;

	logic [NUM_CH-1:0][7:0] src, dst;
	div_req_t [NUM_CH-1:0]  req;
	side_t    [NUM_CH-1:0]  side_f, side_d;
	logic [NUM_CH-1:0][7:0] quo;
	logic [NUM_CH-1:0][7:0] res;

	// advance whenever the output slot is empty or being drained
	assign en           = !out_vld_q || pix_out.ready;
	assign pix_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
		end else if (cfg_we) begin
			mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[PIPE_LEN-2:0], pix_in.valid};
			out_vld_q <= vld_q[PIPE_LEN-1];
		end
	end

	assign src = {pix_in.src_blue, pix_in.src_green, pix_in.src_red};
	assign dst = {pix_in.dst_blue, pix_in.dst_green, pix_in.dst_red};

	lbm_front u_front (
		.clk   (clk),
		.en    (en),
		.src   (src),
		.dst   (dst),
		.alpha (pix_in.alpha),
		.mode  (mode_q),
		.req   (req),
		.side  (side_f)
	);

	for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
		logic [15:0] soft_q;
		logic [8:0]  soft_sum;

		lbm_div u_div (
			.clk      (clk),
			.en       (en),
			.req      (req[c]),
			.side_in  (side_f[c]),
			.quo      (quo[c]),
			.side_out (side_d[c])
		);

		// soft light tail: n + m / 255, saturated
		assign soft_q   = {8'd0, div255(side_d[c].soft_m)};
		assign soft_sum = {1'b0, side_d[c].soft_n} + soft_q[8:0];

		always_comb begin
			case (side_d[c].kind)
				KIND_SIMPLE: res[c] = side_d[c].simple;
				KIND_DIV:    res[c] = quo[c];
				KIND_BURN:   res[c] = 8'd255 - quo[c];
				KIND_SOFT:   res[c] = soft_sum[8] ? 8'd255 : soft_sum[7:0];
				default:     res[c] = side_d[c].simple;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			pix_out.out_red     <= res[0];
			pix_out.out_green   <= res[1];
			pix_out.out_blue    <= res[2];
			pix_out.apply_alpha <= side_d[0].apply;
		end
	end

	assign pix_out.valid = out_vld_q;

endmodule

[src/lbm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbm_front
// four stages: capture, products, divide by 255, mode select / divide setup
// ----------------------------------------------------------------------------
module lbm_front (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic [lbm_pkg::NUM_CH-1:0][7:0]       src,
	input  logic [lbm_pkg::NUM_CH-1:0][7:0]       dst,
	input  logic [7:0]                            alpha,
	input  lbm_pkg::mode_t                        mode,
	output lbm_pkg::div_req_t [lbm_pkg::NUM_CH-1:0] req,
	output lbm_pkg::side_t    [lbm_pkg::NUM_CH-1:0] side
);
	import lbm_pkg::*;

	logic [NUM_CH-1:0][7:0] s_s1, d_s1;
	logic [7:0]             a_s1;
	mode_t                  mode_s1, mode_s2, mode_s3;

	logic [NUM_CH-1:0][7:0]  s_s2, d_s2, s_s3, d_s3;
	logic [NUM_CH-1:0][15:0] sd_s2, ov_s2, sa_s2;
	logic [NUM_CH-1:0][8:0]  sd7_s3, ov7_s3;
	logic [NUM_CH-1:0][7:0]  n_s3, t_s3, t2_s3;

	div_req_t [NUM_CH-1:0] req_s4;
	side_t    [NUM_CH-1:0] side_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1    <= src;
			d_s1    <= dst;
			a_s1    <= alpha;
			mode_s1 <= mode;
			mode_s2 <= mode_s1;
			mode_s3 <= mode_s2;
			s_s2    <= s_s1;
			d_s2    <= d_s1;
			s_s3    <= s_s2;
			d_s3    <= d_s2;
		end
	end

	for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
		logic [7:0]  sn, dn, nt;
		logic [15:0] m;
		logic [15:0] d255;
		logic [8:0]  s2x;
		logic [7:0]  vn;
		logic [8:0]  wn;
		logic signed [11:0] r;
		div_req_t    rq;
		kind_t       k;
		logic [7:0]  simple8;

		assign sn = 8'd255 - s_s1[c];
		assign dn = 8'd255 - d_s1[c];

		always_ff @(posedge clk) begin
			if (en) begin
				sd_s2[c]  <= s_s1[c] * d_s1[c];
				ov_s2[c]  <= sn * dn;
				sa_s2[c]  <= s_s1[c] * a_s1;
				sd7_s3[c] <= sd_s2[c][15:7];
				ov7_s3[c] <= ov_s2[c][15:7];
				n_s3[c]   <= div255(sd_s2[c]);
				t_s3[c]   <= div255(ov_s2[c]);
				t2_s3[c]  <= div255(sa_s2[c]);
			end
		end

		// soft light: d * (255 - n - t); n + t never exceeds 255
		assign nt   = 8'd255 - n_s3[c] - t_s3[c];
		assign m    = d_s3[c] * nt;
		assign d255 = {d_s3[c], 8'd0} - {8'd0, d_s3[c]};
		assign s2x  = {s_s3[c], 1'b0};
		assign vn   = 8'd255 - s2x[7:0];
		assign wn   = 9'd510 - s2x;

		always_comb begin
			r  = '0;
			k  = KIND_SIMPLE;
			rq = '{num: d255, den: 8'd1};
			case (mode_s3)
				MODE_MULTIPLY:   r = 12'(n_s3[c]);
				MODE_ADD:        r = 12'(s_s3[c]) + 12'(d_s3[c]);
				MODE_SUBTRACT:   r = 12'(d_s3[c]) - 12'(s_s3[c]);
				MODE_SCREEN:     r = 12'(s_s3[c]) + 12'(d_s3[c]) - 12'(n_s3[c]);
				MODE_OVERLAY:
					r = d_s3[c][7] ? 12'sd255 - 12'(ov7_s3[c]) : 12'(sd7_s3[c]);
				MODE_HARD_LIGHT:
					r = s_s3[c][7] ? 12'sd255 - 12'(ov7_s3[c]) : 12'(sd7_s3[c]);
				MODE_SOFT_LIGHT: k = KIND_SOFT;
				MODE_DODGE: begin
					if (s_s3[c] == 8'd255) r = 12'sd255;
					else begin
						k  = KIND_DIV;
						rq = '{num: d255, den: 8'd255 - s_s3[c]};
					end
				end
				MODE_BURN: begin
					if (s_s3[c] != 8'd0) begin
						k  = KIND_BURN;
						rq = '{num: {8'd255 - d_s3[c], 8'd0} - {8'd0, 8'd255 - d_s3[c]},
							den: s_s3[c]};
					end
				end
				MODE_LIN_BURN:   r = 12'(d_s3[c]) + 12'(s_s3[c]) - 12'sd255;
				MODE_VIVID: begin
					if (!s_s3[c][7]) begin
						if (!(d_s3[c] <= vn || s_s3[c] == 8'd0)) begin
							k  = KIND_DIV;
							rq = '{num: {d_s3[c] - vn, 8'd0} - {8'd0, d_s3[c] - vn},
								den: s2x[7:0]};
						end
					end else if ({1'b0, d_s3[c]} >= wn || wn == 9'd0) begin
						r = 12'sd255;
					end else begin
						k  = KIND_DIV;
						rq = '{num: d255, den: wn[7:0]};
					end
				end
				MODE_LIN_LIGHT:  r = 12'(s2x) + 12'(d_s3[c]) - 12'sd255;
				MODE_PIN_LIGHT: begin
					if (s_s3[c] > 8'd128)
						r = (12'(s2x) - 12'sd255 < 12'(d_s3[c])) ? 12'(d_s3[c])
							: 12'(s2x) - 12'sd255;
					else
						r = (12'(s2x) > 12'(d_s3[c])) ? 12'(d_s3[c]) : 12'(s2x);
				end
				MODE_DARKEN:
					r = (d_s3[c] < s_s3[c]) ? 12'(d_s3[c]) : 12'(s_s3[c]);
				MODE_LIGHTEN:
					r = (d_s3[c] > s_s3[c]) ? 12'(d_s3[c]) : 12'(s_s3[c]);
				MODE_DIFFERENCE:
					r = (s_s3[c] > d_s3[c]) ? 12'(s_s3[c] - d_s3[c])
						: 12'(d_s3[c] - s_s3[c]);
				MODE_LUM_ADD:    r = 12'(t2_s3[c]) + 12'(d_s3[c]);
				MODE_LUM_DODGE: begin
					if (t2_s3[c] == 8'd255) r = 12'sd255;
					else begin
						k  = KIND_DIV;
						rq = '{num: d255, den: 8'd255 - t2_s3[c]};
					end
				end
				default:         r = 12'(s_s3[c]);
			endcase
			if (r < 0)             simple8 = 8'd0;
			else if (r > 12'sd255) simple8 = 8'd255;
			else                   simple8 = r[7:0];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				req_s4[c]  <= rq;
				side_s4[c] <= '{kind: k, simple: simple8, soft_m: m,
					soft_n: n_s3[c],
					apply: !(mode_s3 == MODE_LUM_ADD || mode_s3 == MODE_LUM_DODGE)};
			end
		end
	end

	assign req  = req_s4;
	assign side = side_s4;

endmodule

[src/lbm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbm_div
// 16 / 8 restoring divider, one quotient bit per stage, result capped at 255
// ----------------------------------------------------------------------------
module lbm_div (
	input  logic              clk,
	input  logic              en,
	input  lbm_pkg::div_req_t req,
	input  lbm_pkg::side_t    side_in,
	output logic [7:0]        quo,
	output lbm_pkg::side_t    side_out
);
	import lbm_pkg::*;

	logic [DIV_BITS:0][7:0] rem_q, lo_q, den_q, quo_q;
	logic [DIV_BITS:0]      ovf_q;
	side_t [DIV_BITS:0]     side_q;

	// load stage: quotient overflows when the high byte already reaches the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= req.num[15:8];
			lo_q[0]   <= req.num[7:0];
			den_q[0]  <= req.den;
			quo_q[0]  <= '0;
			ovf_q[0]  <= req.num[15:8] >= req.den;
			side_q[0] <= side_in;
		end
	end

	for (genvar i = 1; i <= DIV_BITS; i++) begin : g_stage
		logic [8:0] trial;
		logic       take;
		assign trial = {rem_q[i-1], lo_q[i-1][7]};
		assign take  = trial >= {1'b0, den_q[i-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i]  <= take ? 8'(trial - {1'b0, den_q[i-1]}) : trial[7:0];
				lo_q[i]   <= {lo_q[i-1][6:0], 1'b0};
				den_q[i]  <= den_q[i-1];
				quo_q[i]  <= {quo_q[i-1][6:0], take};
				ovf_q[i]  <= ovf_q[i-1];
				side_q[i] <= side_q[i-1];
			end
		end
	end

	assign quo      = ovf_q[DIV_BITS] ? 8'd255 : quo_q[DIV_BITS];
	assign side_out = side_q[DIV_BITS];

endmodule

[sim/lbm_blend_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbm_blend_scoreboard
// predicts blended pixels for accepted requests and checks the output stream
// ----------------------------------------------------------------------------
class lbm_blend_scoreboard;
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       apply;
	} blended_t;

	blended_t    pending_pixels[$];
	lbm_pkg::mode_t mode;
	int          errors;

	function new();
		mode   = lbm_pkg::MODE_NORMAL;
		errors = 0;
	endfunction

	static function int clamp8(int n);
		if (n < 0) return 0;
		if (n > 255) return 255;
		return n;
	endfunction

	function int blend_one(int s, int d, int a);
		int n;
		int t;
		case (mode)
			lbm_pkg::MODE_MULTIPLY:   return s * d / 255;
			lbm_pkg::MODE_ADD:        return s + d;
			lbm_pkg::MODE_SUBTRACT:   return d - s;
			lbm_pkg::MODE_SCREEN:     return s + d - s * d / 255;
			lbm_pkg::MODE_OVERLAY: begin
				if (d < 128) return (s * d) >>> 7;
				return 255 - (((255 - d) * (255 - s)) >>> 7);
			end
			lbm_pkg::MODE_HARD_LIGHT: begin
				if (s < 128) return (s * d) >>> 7;
				return 255 - (((255 - d) * (255 - s)) >>> 7);
			end
			lbm_pkg::MODE_SOFT_LIGHT: begin
				n = s * d / 255;
				t = (255 - s) * (255 - d) / 255;
				return n + d * (255 - n - t) / 255;
			end
			lbm_pkg::MODE_DODGE: begin
				if (s == 255) return 255;
				return d * 255 / (255 - s);
			end
			lbm_pkg::MODE_BURN: begin
				if (s == 0) return 0;
				return 255 - (255 - d) * 255 / s;
			end
			lbm_pkg::MODE_LIN_BURN:   return d + s - 255;
			lbm_pkg::MODE_VIVID: begin
				if (s < 128) begin
					n = 255 - 2 * s;
					if (d <= n || s == 0) return 0;
					return (d - n) * 255 / (2 * s);
				end
				n = 510 - 2 * s;
				if (d >= n || n == 0) return 255;
				return d * 255 / n;
			end
			lbm_pkg::MODE_LIN_LIGHT:  return 2 * s + d - 255;
			lbm_pkg::MODE_PIN_LIGHT: begin
				if (s > 128) begin
					n = 2 * s - 255;
					return (n < d) ? d : n;
				end
				n = 2 * s;
				return (n > d) ? d : n;
			end
			lbm_pkg::MODE_DARKEN:     return (d < s) ? d : s;
			lbm_pkg::MODE_LIGHTEN:    return (d > s) ? d : s;
			lbm_pkg::MODE_DIFFERENCE: return (s > d) ? s - d : d - s;
			lbm_pkg::MODE_LUM_ADD:    return s * a / 255 + d;
			lbm_pkg::MODE_LUM_DODGE: begin
				t = s * a / 255;
				if (t == 255) return 255;
				return d * 255 / (255 - t);
			end
			default:                  return s;
		endcase
	endfunction

	// note an accepted request
	function void note_request(logic [7:0] sr, logic [7:0] sg, logic [7:0] sb,
		logic [7:0] dr, logic [7:0] dg, logic [7:0] db, logic [7:0] a);
		blended_t p;
		p.red   = 8'(clamp8(blend_one(sr, dr, a)));
		p.green = 8'(clamp8(blend_one(sg, dg, a)));
		p.blue  = 8'(clamp8(blend_one(sb, db, a)));
		p.apply = !(mode == lbm_pkg::MODE_LUM_ADD || mode == lbm_pkg::MODE_LUM_DODGE);
		pending_pixels.push_back(p);
	endfunction

	// check one blended pixel against the oldest prediction
	function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic ap);
		blended_t p;
		if (pending_pixels.size() == 0) begin
			$display("%0t: unexpected pixel %h %h %h %b", $time, r, g, b, ap);
			errors++;
			return;
		end
		p = pending_pixels.pop_front();
		if (r !== p.red) begin
			$display("%0t: red expected %h actual %h", $time, p.red, r);
			errors++;
		end
		if (g !== p.green) begin
			$display("%0t: green expected %h actual %h", $time, p.green, g);
			errors++;
		end
		if (b !== p.blue) begin
			$display("%0t: blue expected %h actual %h", $time, p.blue, b);
			errors++;
		end
		if (ap !== p.apply) begin
			$display("%0t: apply_alpha expected %b actual %b", $time, p.apply, ap);
			errors++;
		end
	endfunction
endclass

[sim/tb_layer_blend_mode_8bit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_layer_blend_mode_8bit
// drives pixels through every blend mode with random gaps and output stalls,
// predicting each blended pixel and checking the output stream in order
// ----------------------------------------------------------------------------
module tb_layer_blend_mode_8bit;
	import lbm_pkg::*;

	localparam int LATENCY     = 14;
	localparam int CYCLE_LIMIT = 200000;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic [4:0] cfg_data;
	int        cycle_count;
	bit        long_hold;   // receiver holds off for a long stretch
	bit        gaps_on;     // random idling enabled

	lbm_pix_in_if  pix_in ();
	lbm_pix_out_if pix_out ();

	lbm_blend_scoreboard blend_board;

	layer_blend_mode_8bit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in.sink),
		.pix_out (pix_out.source),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** layer_blend_mode_8bit: FAILED **");
			$finish;
		end
	end

	// output side: sample at rising edge, check accepted pixels
	always @(posedge clk) begin
		if (arst_n && pix_out.valid && pix_out.ready)
			blend_board.check_pixel(pix_out.out_red, pix_out.out_green,
				pix_out.out_blue, pix_out.apply_alpha);
	end

	// receiver stalls, changed on the falling edge
	initial begin
		int wait_cycles;
		pix_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				pix_out.ready <= 1'b0;
				repeat (60) @(negedge clk);
				long_hold = 1'b0;
			end
			wait_cycles = gaps_on ? $urandom_range(0, 11) : 0;
			if (wait_cycles > 0 && $urandom_range(0, 3) != 0) begin
				pix_out.ready <= 1'b0;
				repeat (wait_cycles - 1) @(negedge clk);
			end else begin
				pix_out.ready <= 1'b1;
			end
		end
	end

	// offer one pixel and wait for it to be taken
	task automatic send_pixel(logic [7:0] sr, logic [7:0] sg, logic [7:0] sb,
		logic [7:0] dr, logic [7:0] dg, logic [7:0] db, logic [7:0] a);
		int gap;
		gap = (gaps_on && $urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			pix_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_in.valid     <= 1'b1;
		pix_in.src_red   <= sr;
		pix_in.src_green <= sg;
		pix_in.src_blue  <= sb;
		pix_in.dst_red   <= dr;
		pix_in.dst_green <= dg;
		pix_in.dst_blue  <= db;
		pix_in.alpha     <= a;
		do @(posedge clk); while (!pix_in.ready);
		blend_board.note_request(sr, sg, sb, dr, dg, db, a);
		@(negedge clk);
	endtask

	task automatic send_random_pixel();
		logic [7:0] v[7];
		foreach (v[i]) begin
			case ($urandom_range(0, 5))
				0: v[i] = 8'd0;
				1: v[i] = 8'd255;
				2: v[i] = 8'(127 + $urandom_range(0, 2));
				default: v[i] = 8'($urandom);
			endcase
		end
		send_pixel(v[0], v[1], v[2], v[3], v[4], v[5], v[6]);
	endtask

	// wait until the pipe is empty, then write the mode register
	task automatic set_mode(mode_t m);
		pix_in.valid <= 1'b0;
		while (blend_board.pending_pixels.size() != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		blend_board.mode = m;
	endtask

	initial begin
		blend_board  = new();
		cycle_count  = 0;
		long_hold    = 1'b0;
		gaps_on      = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_data     = '0;
		pix_in.valid = 1'b0;
		pix_in.src_red = '0; pix_in.src_green = '0; pix_in.src_blue = '0;
		pix_in.dst_red = '0; pix_in.dst_green = '0; pix_in.dst_blue = '0;
		pix_in.alpha = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset mode is normal, then corners in the tricky modes
		send_pixel(8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd127, 8'd255);
		set_mode(MODE_DODGE);
		send_pixel(8'd255, 8'd254, 8'd0, 8'd0, 8'd255, 8'd200, 8'd0);
		set_mode(MODE_BURN);
		send_pixel(8'd0, 8'd1, 8'd255, 8'd255, 8'd0, 8'd100, 8'd0);
		set_mode(MODE_VIVID);
		// zero divisor on both branches, s = 0, and regular divides
		send_pixel(8'd0, 8'd255, 8'd127, 8'd0, 8'd255, 8'd1, 8'd0);
		send_pixel(8'd128, 8'd200, 8'd1, 8'd254, 8'd10, 8'd254, 8'd0);
		set_mode(MODE_LUM_DODGE);
		// scaled source of 255 saturates
		send_pixel(8'd255, 8'd254, 8'd0, 8'd10, 8'd200, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd128, 8'd1, 8'd10, 8'd200, 8'd255, 8'd254);
		set_mode(MODE_PIN_LIGHT);
		send_pixel(8'd128, 8'd129, 8'd0, 8'd255, 8'd0, 8'd100, 8'd0);
		set_mode(5'd31);  // undefined code acts as normal
		send_pixel(8'd17, 8'd255, 8'd0, 8'd99, 8'd0, 8'd255, 8'd0);

		// random: every mode including undefined codes, with idling
		gaps_on = 1'b1;
		for (int m = 0; m < 32; m++) begin
			set_mode(mode_t'(m));
			if (m == 3) long_hold = 1'b1;   // block fills up and stalls input
			for (int i = 0; i < ((m < 19) ? 40 : 12); i++) begin
				if (i == 20 && $urandom_range(0, 1) == 0) gaps_on = 1'b0;
				if (i == 30) gaps_on = 1'b1;
				send_random_pixel();
			end
		end
		set_mode(MODE_NORMAL);

		while (blend_board.pending_pixels.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		if (blend_board.errors == 0)
			$display("** layer_blend_mode_8bit: PASSED **");
		else
			$display("** layer_blend_mode_8bit: FAILED **");
		$finish;
	end
endmodule
